// ----- src/brf_pkg.sv -----
// Shared types, field widths and helpers for the byte ring FIFO.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int CAP_W  = 9;
    localparam int OP_W   = 2;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    // Largest power of two not above x; zero maps to one.
    function automatic logic [CAP_W-1:0] floor_pow2(input logic [CAP_W-1:0] x);
        logic [CAP_W-1:0] p;
        p = {{(CAP_W-1){1'b0}}, 1'b1};
        for (int i = 0; i < CAP_W; i++) begin
            if (x[i]) begin
                p = '0;
                p[i] = 1'b1;
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- src/byte_ring_fifo.sv -----
// Byte FIFO over a power-of-two ring: control, counters and output register.
// Depends on brf_pkg and brf_ram.
//
//  channel | dir | handshake                | payload
//  s_      | in  | s_tvalid / s_tready      | s_tuser opcode, s_tdata byte + length
//  m_      | out | m_tvalid / m_tready      | m_tdata byte/status, m_tuser, m_tlast
//  cfg_    | in  | cfg_valid / cfg_ready    | cfg_data capacity
//
// Write, clear and status requests stream back to back while m_ does not stall.
// A read request of n bytes, capped at MAX_READ and the fill level, issues ring
// RAM reads, then moves one byte per cycle out of the registered RAM read port.
// Reset empties the FIFO and sets the ring to its full size; RAM contents
// are not cleared. A stall on m_ holds the output register and the RAM read.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_fifo
    import brf_pkg::*;
#(
    parameter int DEPTH    = 256,
    parameter int MAX_READ = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // write_byte[7:0], read_length[14:8]
    input  wire logic [OP_W-1:0]       s_tuser,   // opcode[1:0]

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,   // read_byte[7:0], write_accepted[8],
                                                  // fill_level[17:9], free_space[26:18]
    output logic      [0:0]            m_tuser,   // byte_valid[0]
    output logic                       m_tlast,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CAP_W-1:0]      cfg_data
);

    localparam int TOP   = 2 ** ($clog2(DEPTH + 1) - 1);
    localparam int CW    = $clog2(TOP) + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = (CW > LEN_W) ? CW : LEN_W;

    state_t state_reg, state_next;

    logic [CW-1:0]    wr_cnt_reg, wr_cnt_next;
    logic [CW-1:0]    rd_cnt_reg, rd_cnt_next;
    logic [CW-1:0]    ring_reg, ring_next;
    logic [CW-1:0]    iss_reg, iss_next;
    logic [LEN_W-1:0] iss_left_reg, iss_left_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic             pend_reg, pend_next;

    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_byte_reg, m_byte_next;
    logic              m_bvalid_reg, m_bvalid_next;
    logic              m_last_reg, m_last_next;
    logic              m_acc_reg, m_acc_next;
    logic [CAP_W-1:0]  m_fill_reg, m_fill_next;
    logic [CAP_W-1:0]  m_free_reg, m_free_next;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic              out_free, s_acc, cfg_acc, move, issue;
    op_t               op;
    logic [BYTE_W-1:0] wr_byte;
    logic [LEN_W-1:0]  rd_len, rd_len_sat, rd_n;
    logic [CW-1:0]     fill, fill_wr, fill_pop, ring_mask;
    logic              full;

    assign op      = op_t'(s_tuser);
    assign wr_byte = s_tdata[BYTE_W-1:0];
    assign rd_len  = s_tdata[BYTE_W+LEN_W-1:BYTE_W];

    assign out_free  = !m_valid_reg || m_tready;
    assign fill      = wr_cnt_reg - rd_cnt_reg;
    assign fill_wr   = wr_cnt_reg + CW'(1) - rd_cnt_reg;
    assign fill_pop  = wr_cnt_reg - rd_cnt_reg - CW'(1);
    assign ring_mask = ring_reg - CW'(1);
    assign full      = !(fill < ring_reg);

    assign rd_len_sat = (rd_len > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : rd_len;
    assign rd_n       = (CMP_W'(fill) < CMP_W'(rd_len_sat)) ? LEN_W'(fill) : rd_len_sat;

    assign move  = (state_reg == ST_READ) && pend_reg && out_free;
    assign issue = (state_reg == ST_READ) && (iss_left_reg != '0) && (!pend_reg || move);

    assign s_acc   = s_tvalid && s_tready;
    assign cfg_acc = cfg_valid && cfg_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && op == OP_READ && rd_n != '0) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (move && rem_reg == LEN_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and RAM control
    always_comb begin
        s_tready  = 1'b0;
        cfg_ready = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_tready  = out_free && !cfg_valid;
                ram_we    = s_acc && op == OP_WRITE && !full;
            end
            ST_READ: begin
                ram_re = issue;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign ram_waddr = AW'(wr_cnt_reg & ring_mask) & AW'(DEPTH - 1);
    assign ram_raddr = AW'(iss_reg & ring_mask) & AW'(DEPTH - 1);

    // Datapath next values
    always_comb begin
        wr_cnt_next   = wr_cnt_reg;
        rd_cnt_next   = rd_cnt_reg;
        ring_next     = ring_reg;
        iss_next      = iss_reg;
        iss_left_next = iss_left_reg;
        rem_next      = rem_reg;
        pend_next     = pend_reg;

        m_valid_next  = m_valid_reg && !m_tready;
        m_byte_next   = m_byte_reg;
        m_bvalid_next = m_bvalid_reg;
        m_last_next   = m_last_reg;
        m_acc_next    = m_acc_reg;
        m_fill_next   = m_fill_reg;
        m_free_next   = m_free_reg;

        if (cfg_acc) begin
            if (int'(cfg_data) >= TOP) begin
                ring_next = CW'(TOP);
            end else begin
                ring_next = CW'(floor_pow2(cfg_data));
            end
            wr_cnt_next = '0;
            rd_cnt_next = '0;
        end

        if (s_acc) begin
            m_valid_next  = 1'b1;
            m_byte_next   = '0;
            m_bvalid_next = 1'b0;
            m_last_next   = 1'b1;
            m_acc_next    = 1'b0;
            m_fill_next   = CAP_W'(fill);
            m_free_next   = CAP_W'(ring_reg - fill);
            case (op)
                OP_WRITE: begin
                    if (!full) begin
                        wr_cnt_next = wr_cnt_reg + CW'(1);
                        m_acc_next  = 1'b1;
                        m_fill_next = CAP_W'(fill_wr);
                        m_free_next = CAP_W'(ring_reg - fill_wr);
                    end
                end
                OP_READ: begin
                    if (rd_n != '0) begin
                        m_valid_next  = 1'b0;
                        iss_next      = rd_cnt_reg;
                        iss_left_next = rd_n;
                        rem_next      = rd_n;
                        pend_next     = 1'b0;
                    end
                end
                OP_CLEAR: begin
                    wr_cnt_next = '0;
                    rd_cnt_next = '0;
                    m_fill_next = '0;
                    m_free_next = CAP_W'(ring_reg);
                end
                default: begin
                    m_acc_next = 1'b0;
                end
            endcase
        end

        if (issue) begin
            iss_next      = iss_reg + CW'(1);
            iss_left_next = iss_left_reg - LEN_W'(1);
        end
        if (issue) begin
            pend_next = 1'b1;
        end else if (move) begin
            pend_next = 1'b0;
        end

        if (move) begin
            rd_cnt_next   = rd_cnt_reg + CW'(1);
            rem_next      = rem_reg - LEN_W'(1);
            m_valid_next  = 1'b1;
            m_byte_next   = ram_rdata;
            m_bvalid_next = 1'b1;
            m_last_next   = (rem_reg == LEN_W'(1));
            m_acc_next    = 1'b0;
            m_fill_next   = CAP_W'(fill_pop);
            m_free_next   = CAP_W'(ring_reg - fill_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wr_cnt_reg   <= '0;
            rd_cnt_reg   <= '0;
            ring_reg     <= CW'(TOP);
            iss_left_reg <= '0;
            rem_reg      <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wr_cnt_reg   <= wr_cnt_next;
            rd_cnt_reg   <= rd_cnt_next;
            ring_reg     <= ring_next;
            iss_left_reg <= iss_left_next;
            rem_reg      <= rem_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
        iss_reg      <= iss_next;
        m_byte_reg   <= m_byte_next;
        m_bvalid_reg <= m_bvalid_next;
        m_last_reg   <= m_last_next;
        m_acc_reg    <= m_acc_next;
        m_fill_reg   <= m_fill_next;
        m_free_reg   <= m_free_next;
    end

    brf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (wr_byte),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_bvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - BYTE_W - 1 - 2*CAP_W){1'b0}},
                       m_free_reg, m_fill_reg, m_acc_reg, m_byte_reg};

endmodule

`default_nettype wire

// ----- src/brf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
